[rtl/time_ordered_history_table_core_assert.svh]
// Assertion macros used by the checker file of the history table.
// Both macros sample on clk and stay quiet while rst_n is low.
`ifndef TIME_ORDERED_HISTORY_TABLE_CORE_ASSERT_SVH
`define TIME_ORDERED_HISTORY_TABLE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TOHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("history table check failed");

// Consequent must hold in the cycle after the antecedent.
`define TOHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("history table check failed");

`endif

[rtl/toht_pkg.sv]
package toht_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W        = 32;
    localparam int TOTAL_W       = 7;
    localparam int OP_W          = 2;
    localparam int STAT_W        = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int DEPTH_DEFAULT = 64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEEK   = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DUP     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VALUE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_IS_NULL = 1'b1;

    // One table entry as held in the store.
    typedef struct packed {
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] value;
        logic              is_null;
    } entry_t;

endpackage

[rtl/toht_store.sv]
module toht_store #(
    parameter int DEPTH = toht_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  toht_pkg::entry_t         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output toht_pkg::entry_t         rd_data
);

    toht_pkg::entry_t mem [DEPTH];

    // One write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/time_ordered_history_table_core.sv]
// Flow: an unused op code goes straight to fetch and load of the result beat. Other codes scan
// the table entry by entry, decide, shift entries and write the new entry for an insert, then
// fetch and load; a result that waits on out_ready holds the block in load.
// One item at a time; a new beat is taken the cycle after the result is loaded.
// Reset: empty table, no cursor entry, default 0 flagged null; the store is not cleared.
module time_ordered_history_table_core #(
    parameter int DEPTH = toht_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [toht_pkg::OP_W-1:0]      op,
    input  logic [toht_pkg::DATA_W-1:0]    key_time,
    input  logic [toht_pkg::DATA_W-1:0]    entry_value,
    input  logic                           entry_is_null,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [toht_pkg::DATA_W-1:0]    cur_value,
    output logic [toht_pkg::DATA_W-1:0]    cur_time,
    output logic                           cur_is_null,
    output logic                           table_empty,
    output logic [toht_pkg::TOTAL_W-1:0]   entry_total,
    output logic [toht_pkg::STAT_W-1:0]    status,
    input  logic                           cfg_we,
    input  logic [toht_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [toht_pkg::DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_WRITE_NEW,
        S_FETCH,
        S_LOAD
    } state_t;

    state_t                          state_reg, state_next;
    logic [toht_pkg::OP_W-1:0]       op_reg, op_next;
    logic [toht_pkg::DATA_W-1:0]     key_reg, key_next;
    logic [toht_pkg::DATA_W-1:0]     val_reg, val_next;
    logic                            nul_reg, nul_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]                pos_reg, pos_next;
    logic                            hit_reg, hit_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            cur_some_reg, cur_some_next;
    logic [IDX_W-1:0]                cur_idx_reg, cur_idx_next;
    logic [toht_pkg::STAT_W-1:0]     stat_reg, stat_next;
    logic [toht_pkg::DATA_W-1:0]     dflt_value_reg, dflt_value_next;
    logic                            dflt_null_reg, dflt_null_next;
    logic                            out_valid_reg, out_valid_next;
    logic [toht_pkg::DATA_W-1:0]     cur_value_reg, cur_value_next;
    logic [toht_pkg::DATA_W-1:0]     cur_time_reg, cur_time_next;
    logic                            cur_null_reg, cur_null_next;
    logic                            empty_reg, empty_next;
    logic [toht_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic [toht_pkg::STAT_W-1:0]     status_reg, status_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    toht_pkg::entry_t wr_data;
    logic [IDX_W-1:0] rd_addr;
    toht_pkg::entry_t rd_data;

    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;
    logic [CNT_W-1:0] pos_inc;
    logic [CNT_W-1:0] count_dec;
    logic             scan_on;
    logic             named;

    assign idx_inc   = idx_reg + CNT_ONE;
    assign idx_dec   = idx_reg - CNT_ONE;
    assign pos_inc   = pos_reg + CNT_ONE;
    assign count_dec = count_reg - CNT_ONE;

    // A seek walks past entries at or before the key; insert and delete stop at the first
    // entry not below it.
    assign scan_on = (op_reg == toht_pkg::OP_SEEK) ? (rd_data.stamp <= key_reg)
                                                   : (rd_data.stamp < key_reg);

    // The cursor may point past the table after deletes; it then names nothing.
    assign named = cur_some_reg && (CNT_W'(cur_idx_reg) < count_reg);

    toht_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: scan, decide, shift, write, then fetch the cursor entry and load the result.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        nul_next        = nul_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        count_next      = count_reg;
        cur_some_next   = cur_some_reg;
        cur_idx_next    = cur_idx_reg;
        stat_next       = stat_reg;
        dflt_value_next = dflt_value_reg;
        dflt_null_next  = dflt_null_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cur_value_next  = cur_value_reg;
        cur_time_next   = cur_time_reg;
        cur_null_next   = cur_null_reg;
        empty_next      = empty_reg;
        total_next      = total_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '{stamp: key_reg, value: val_reg, is_null: nul_reg};
        rd_addr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = op;
                    key_next  = key_time;
                    val_next  = entry_value;
                    nul_next  = entry_is_null;
                    idx_next  = '0;
                    pos_next  = '0;
                    hit_next  = 1'b0;
                    stat_next = toht_pkg::STAT_DONE;
                    if (op != toht_pkg::OP_INSERT && op != toht_pkg::OP_DELETE &&
                        op != toht_pkg::OP_SEEK)
                    begin
                        state_next = S_FETCH;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            // Read data belongs to entry idx; the next entry is read ahead.
            S_SCAN:
            begin
                if (scan_on)
                begin
                    idx_next = idx_inc;
                    rd_addr  = idx_inc[IDX_W-1:0];
                    if (idx_inc == count_reg)
                    begin
                        pos_next   = count_reg;
                        hit_next   = 1'b0;
                        state_next = S_DECIDE;
                    end
                end
                else
                begin
                    pos_next   = idx_reg;
                    hit_next   = (rd_data.stamp == key_reg);
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = S_FETCH;
                case (op_reg)
                    toht_pkg::OP_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            stat_next = toht_pkg::STAT_DUP;
                        end
                        else if (count_reg == CNT_FULL)
                        begin
                            stat_next = toht_pkg::STAT_FULL;
                        end
                        else if (pos_reg == count_reg)
                        begin
                            state_next = S_WRITE_NEW;
                        end
                        else
                        begin
                            idx_next   = count_dec;
                            rd_addr    = count_dec[IDX_W-1:0];
                            state_next = S_SHIFT;
                        end
                    end
                    toht_pkg::OP_DELETE:
                    begin
                        if (!hit_reg)
                        begin
                            stat_next = toht_pkg::STAT_MISSING;
                        end
                        else if (pos_inc == count_reg)
                        begin
                            count_next = count_dec;
                        end
                        else
                        begin
                            idx_next   = pos_inc;
                            rd_addr    = pos_inc[IDX_W-1:0];
                            state_next = S_SHIFT;
                        end
                    end
                    toht_pkg::OP_SEEK:
                    begin
                        cur_some_next = (pos_reg != '0);
                        cur_idx_next  = idx_dec[IDX_W-1:0];
                        if (pos_reg != '0)
                        begin
                            cur_idx_next = pos_reg[IDX_W-1:0] - IDX_W'(1);
                        end
                    end
                    default:
                    begin
                        stat_next = toht_pkg::STAT_DONE;
                    end
                endcase
            end

            // One entry moves per cycle: up by one for insert, down by one for delete.
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                if (op_reg == toht_pkg::OP_INSERT)
                begin
                    wr_addr = idx_inc[IDX_W-1:0];
                    if (idx_reg == pos_reg)
                    begin
                        state_next = S_WRITE_NEW;
                    end
                    else
                    begin
                        idx_next = idx_dec;
                        rd_addr  = idx_dec[IDX_W-1:0];
                    end
                end
                else
                begin
                    wr_addr = idx_dec[IDX_W-1:0];
                    if (idx_inc == count_reg)
                    begin
                        count_next = count_dec;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        rd_addr  = idx_inc[IDX_W-1:0];
                    end
                end
            end

            S_WRITE_NEW:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[IDX_W-1:0];
                count_next = count_reg + CNT_ONE;
                state_next = S_FETCH;
            end

            S_FETCH:
            begin
                rd_addr    = cur_idx_reg;
                state_next = S_LOAD;
            end

            // The result register is loaded once the previous beat has left. The cursor
            // entry stays on the read port while the block waits.
            S_LOAD:
            begin
                rd_addr = cur_idx_reg;
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (named)
                    begin
                        cur_value_next = rd_data.value;
                        cur_time_next  = rd_data.stamp;
                        cur_null_next  = rd_data.is_null;
                    end
                    else
                    begin
                        cur_value_next = dflt_value_reg;
                        cur_time_next  = '0;
                        cur_null_next  = dflt_null_reg;
                    end
                    empty_next  = (count_reg == '0);
                    total_next  = toht_pkg::TOTAL_W'(count_reg);
                    status_next = stat_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The user must write configuration only while the block is idle; the block does not enforce it.
        if (cfg_we)
        begin
            case (cfg_index)
                toht_pkg::REG_DEFAULT_VALUE:   dflt_value_next = cfg_data;
                toht_pkg::REG_DEFAULT_IS_NULL: dflt_null_next  = cfg_data[0];
                default:                       dflt_null_next  = dflt_null_reg;
            endcase
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            key_reg        <= '0;
            val_reg        <= '0;
            nul_reg        <= 1'b0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            hit_reg        <= 1'b0;
            count_reg      <= '0;
            cur_some_reg   <= 1'b0;
            cur_idx_reg    <= '0;
            stat_reg       <= toht_pkg::STAT_DONE;
            dflt_value_reg <= '0;
            dflt_null_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
            cur_value_reg  <= '0;
            cur_time_reg   <= '0;
            cur_null_reg   <= 1'b0;
            empty_reg      <= 1'b1;
            total_reg      <= '0;
            status_reg     <= toht_pkg::STAT_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            nul_reg        <= nul_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            hit_reg        <= hit_next;
            count_reg      <= count_next;
            cur_some_reg   <= cur_some_next;
            cur_idx_reg    <= cur_idx_next;
            stat_reg       <= stat_next;
            dflt_value_reg <= dflt_value_next;
            dflt_null_reg  <= dflt_null_next;
            out_valid_reg  <= out_valid_next;
            cur_value_reg  <= cur_value_next;
            cur_time_reg   <= cur_time_next;
            cur_null_reg   <= cur_null_next;
            empty_reg      <= empty_next;
            total_reg      <= total_next;
            status_reg     <= status_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cur_value   = cur_value_reg;
    assign cur_time    = cur_time_reg;
    assign cur_is_null = cur_null_reg;
    assign table_empty = empty_reg;
    assign entry_total = total_reg;
    assign status      = status_reg;

endmodule

[rtl/toht_checker.sv]
`include "time_ordered_history_table_core_assert.svh"

module toht_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [toht_pkg::DATA_W-1:0]  cur_value,
    input logic [toht_pkg::DATA_W-1:0]  cur_time,
    input logic                         table_empty,
    input logic [toht_pkg::TOTAL_W-1:0] entry_total,
    input logic [toht_pkg::STAT_W-1:0]  status
);

    // A stalled result beat holds its payload.
    `TOHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cur_value) && $stable(cur_time) && $stable(status))

    // The block works on one item at a time.
    `TOHT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // An empty table reports no entries.
    `TOHT_ASSERT_NOW(a_empty_total, out_valid && table_empty, entry_total == '0)

    // Full and duplicate outcomes need a table that holds entries.
    `TOHT_ASSERT_NOW(a_full_dup_not_empty, out_valid && (status == toht_pkg::STAT_FULL || status == toht_pkg::STAT_DUP), !table_empty)

endmodule

bind time_ordered_history_table_core toht_checker u_toht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cur_value   (cur_value),
    .cur_time    (cur_time),
    .table_empty (table_empty),
    .entry_total (entry_total),
    .status      (status)
);

[sim/time_ordered_history_table_core_tb.sv]
// One result beat as the block reports it.
typedef struct packed {
    logic [toht_pkg::DATA_W-1:0]  value;
    logic [toht_pkg::DATA_W-1:0]  stamp;
    logic                         is_null;
    logic                         empty;
    logic [toht_pkg::TOTAL_W-1:0] total;
    logic [toht_pkg::STAT_W-1:0]  status;
} cursor_view_t;

// Mirror of the sorted history table. It applies each accepted item to its own
// copy of the table and queues the cursor view that the block must report.
class table_mirror;
    bit [toht_pkg::DATA_W-1:0] stamps [toht_pkg::DEPTH_DEFAULT];
    bit [toht_pkg::DATA_W-1:0] values [toht_pkg::DEPTH_DEFAULT];
    bit                        nulls  [toht_pkg::DEPTH_DEFAULT];
    int                        count;
    int                        cursor;
    bit [toht_pkg::DATA_W-1:0] dflt_value;
    bit                        dflt_null;
    cursor_view_t              due_views [$];
    int                        failures;
    int                        op_seen [4];
    int                        status_seen [4];
    int                        peak_count;
    int                        default_reports;

    function void clear_table();
        count      = 0;
        cursor     = -1;
        dflt_value = '0;
        dflt_null  = 1'b1;
        failures   = 0;
        peak_count = 0;
        default_reports = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        due_views.delete();
    endfunction

    function void set_register(logic [toht_pkg::CFG_IDX_W-1:0] idx,
                               logic [toht_pkg::DATA_W-1:0] data);
        if (idx == toht_pkg::REG_DEFAULT_VALUE)
            dflt_value = data;
        else
            dflt_null = data[0];
    endfunction

    // First slot whose stamp is not below t, or count when there is none.
    function int lower_slot(logic [toht_pkg::DATA_W-1:0] t);
        int i;
        i = 0;
        while (i < count && stamps[i] < t)
            i++;
        return i;
    endfunction

    // Apply one accepted input beat and queue the view it must produce.
    function void apply_item(logic [toht_pkg::OP_W-1:0] op, logic [toht_pkg::DATA_W-1:0] t,
                             logic [toht_pkg::DATA_W-1:0] v, logic n);
        int pos;
        int k;
        logic [toht_pkg::STAT_W-1:0] st;
        cursor_view_t view;
        st = toht_pkg::STAT_DONE;
        case (op)
            toht_pkg::OP_INSERT:
            begin
                pos = lower_slot(t);
                if (pos < count && stamps[pos] == t)
                    st = toht_pkg::STAT_DUP;
                else if (count >= toht_pkg::DEPTH_DEFAULT)
                    st = toht_pkg::STAT_FULL;
                else
                begin
                    for (k = count; k > pos; k--)
                    begin
                        stamps[k] = stamps[k-1];
                        values[k] = values[k-1];
                        nulls[k]  = nulls[k-1];
                    end
                    stamps[pos] = t;
                    values[pos] = v;
                    nulls[pos]  = n;
                    count++;
                end
            end
            toht_pkg::OP_DELETE:
            begin
                pos = lower_slot(t);
                if (pos >= count || stamps[pos] != t)
                    st = toht_pkg::STAT_MISSING;
                else
                begin
                    for (k = pos; k + 1 < count; k++)
                    begin
                        stamps[k] = stamps[k+1];
                        values[k] = values[k+1];
                        nulls[k]  = nulls[k+1];
                    end
                    count--;
                end
            end
            toht_pkg::OP_SEEK:
            begin
                // The cursor lands on the last entry at or before t.
                k = 0;
                while (k < count && stamps[k] <= t)
                    k++;
                cursor = k - 1;
            end
            default:
            begin
                // The unused code changes nothing.
            end
        endcase

        // A cursor past the end after deletes names no entry.
        if (cursor >= 0 && cursor < count)
        begin
            view.value   = values[cursor];
            view.stamp   = stamps[cursor];
            view.is_null = nulls[cursor];
        end
        else
        begin
            view.value   = dflt_value;
            view.stamp   = '0;
            view.is_null = dflt_null;
            default_reports++;
        end
        view.empty  = (count == 0);
        view.total  = toht_pkg::TOTAL_W'(count);
        view.status = st;
        due_views.push_back(view);

        op_seen[op]++;
        status_seen[st]++;
        if (count > peak_count)
            peak_count = count;
    endfunction

    function void compare_field(string name, logic [toht_pkg::DATA_W-1:0] want,
                                logic [toht_pkg::DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // Check one accepted result beat against the oldest queued view.
    function void check_view(cursor_view_t got);
        cursor_view_t want;
        if (due_views.size() == 0)
        begin
            $error("result beat with no item pending: value 0x%0h time 0x%0h status %0d",
                   got.value, got.stamp, got.status);
            failures++;
            return;
        end
        want = due_views.pop_front();
        compare_field("cur_value", want.value, got.value);
        compare_field("cur_time", want.stamp, got.stamp);
        compare_field("cur_is_null", 32'(want.is_null), 32'(got.is_null));
        compare_field("table_empty", 32'(want.empty), 32'(got.empty));
        compare_field("entry_total", 32'(want.total), 32'(got.total));
        compare_field("status", 32'(want.status), 32'(got.status));
    endfunction
endclass

module time_ordered_history_table_core_tb;

    import toht_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int BIAS_FILL  = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_SEEK  = 2;
    localparam int BIAS_MIX   = 3;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int unsigned RUN_LIMIT = 20_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [OP_W-1:0]      op = OP_SEEK;
    logic [DATA_W-1:0]    key_time = '0;
    logic [DATA_W-1:0]    entry_value = '0;
    logic                 entry_is_null = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DATA_W-1:0]    cur_value;
    logic [DATA_W-1:0]    cur_time;
    logic                 cur_is_null;
    logic                 table_empty;
    logic [TOTAL_W-1:0]   entry_total;
    logic [STAT_W-1:0]    status;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DEFAULT_VALUE;
    logic [DATA_W-1:0]    cfg_data = '0;

    table_mirror          mirror;
    logic [DATA_W-1:0]    key_base;
    int                   key_window;
    int                   settings_written;
    int                   rx_mode;
    int                   rx_tick;
    int                   rx_hold;

    time_ordered_history_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .key_time      (key_time),
        .entry_value   (entry_value),
        .entry_is_null (entry_is_null),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cur_value     (cur_value),
        .cur_time      (cur_time),
        .cur_is_null   (cur_is_null),
        .table_empty   (table_empty),
        .entry_total   (entry_total),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("Timed out with %0d result beats outstanding.", mirror.due_views.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver side: check each result beat, then pick ready from a pattern
    // that switches between always ready, coin flips and long stalls.
    always @(posedge clk)
    begin : result_side
        cursor_view_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {cur_value, cur_time, cur_is_null, table_empty, entry_total, status};
            mirror.check_view(got);
        end
        rx_tick++;
        if (rx_tick % 300 == 0)
            rx_mode = $urandom_range(0, 2);
        if (rx_hold > 0)
        begin
            rx_hold--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        rx_hold = $urandom_range(1, 32);
                        out_ready <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
                end
            endcase
        end
    end

    // Present one input beat and hold it until the block takes it.
    task automatic send_item(input logic [OP_W-1:0] o, input logic [DATA_W-1:0] t,
                             input logic [DATA_W-1:0] v, input logic n);
        in_valid      <= 1'b1;
        op            <= o;
        key_time      <= t;
        entry_value   <= v;
        entry_is_null <= n;
        do
            @(posedge clk);
        while (!in_ready);
        mirror.apply_item(o, t, v, n);
    endtask

    task automatic idle_cycles(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every queued view has been checked.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (mirror.due_views.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Write both registers on back-to-back cycles; upper bits of the flag
    // word carry noise that the block must ignore.
    task automatic write_defaults(input logic [DATA_W-1:0] dv, input logic dn);
        logic [DATA_W-1:0] flag_word;
        flag_word    = $urandom;
        flag_word[0] = dn;
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEFAULT_VALUE;
        cfg_data  <= dv;
        @(posedge clk);
        mirror.set_register(REG_DEFAULT_VALUE, dv);
        cfg_index <= REG_DEFAULT_IS_NULL;
        cfg_data  <= flag_word;
        @(posedge clk);
        mirror.set_register(REG_DEFAULT_IS_NULL, flag_word);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    // Keys mostly hit live entries or a narrow window so that duplicates,
    // exact deletes and near seeks are common; the rest span the full range.
    function automatic logic [DATA_W-1:0] pick_key(input logic for_seek);
        int roll;
        logic [DATA_W-1:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 35 && mirror.count > 0)
        begin
            k = mirror.stamps[$urandom_range(0, mirror.count - 1)];
            if (for_seek)
                k = k + DATA_W'($urandom_range(0, 2)) - 1;
        end
        else if (roll < 75)
            k = key_base + DATA_W'($urandom_range(0, key_window));
        else if (roll < 95)
            k = $urandom;
        else if (roll < 97)
            k = '0;
        else
            k = '1;
        return k;
    endfunction

    function automatic void pick_item(input int bias, output logic [OP_W-1:0] o,
                                      output logic [DATA_W-1:0] t,
                                      output logic [DATA_W-1:0] v, output logic n);
        int roll;
        int ins_cut;
        int del_cut;
        int seek_cut;
        case (bias)
            BIAS_FILL:  begin ins_cut = 80; del_cut = 88; seek_cut = 98; end
            BIAS_DRAIN: begin ins_cut = 20; del_cut = 80; seek_cut = 97; end
            BIAS_SEEK:  begin ins_cut = 25; del_cut = 40; seek_cut = 97; end
            default:    begin ins_cut = 40; del_cut = 65; seek_cut = 96; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_cut)
            o = OP_INSERT;
        else if (roll < del_cut)
            o = OP_DELETE;
        else if (roll < seek_cut)
            o = OP_SEEK;
        else
            o = OP_UNUSED;
        t = pick_key(o == OP_SEEK);
        v = $urandom;
        n = 1'($urandom_range(0, 1));
    endfunction

    // Hand-picked sequence on the reset defaults: empty table, extreme keys,
    // duplicates, seeks before, on and past the entries, a cursor left past
    // the end by a delete, missing deletes and the unused code.
    task automatic run_directed();
        send_item(OP_SEEK, 32'd100, $urandom, 1'b0);
        send_item(OP_DELETE, 32'd100, $urandom, 1'b1);
        send_item(OP_UNUSED, $urandom, $urandom, 1'b0);
        send_item(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_INSERT, 32'h0000_0000, 32'h0000_007B, 1'b1);
        send_item(OP_INSERT, 32'd1000, 32'hA5A5_A5A5, 1'b0);
        send_item(OP_SEEK, 32'h0000_0000, $urandom, 1'b1);
        send_item(OP_INSERT, 32'd500, 32'h5A5A_5A5A, 1'b1);
        send_item(OP_SEEK, 32'd999, $urandom, 1'b0);
        send_item(OP_SEEK, 32'hFFFF_FFFF, $urandom, 1'b0);
        send_item(OP_DELETE, 32'd1000, $urandom, 1'b0);
        send_item(OP_UNUSED, $urandom, $urandom, 1'b1);
        send_item(OP_DELETE, 32'd1000, $urandom, 1'b0);
        send_item(OP_SEEK, 32'd1000, $urandom, 1'b0);
        send_item(OP_DELETE, 32'h0000_0000, $urandom, 1'b0);
        send_item(OP_SEEK, 32'h0000_0000, $urandom, 1'b0);
        send_item(OP_SEEK, 32'd499, $urandom, 1'b1);
        send_item(OP_SEEK, 32'd500, $urandom, 1'b0);
        send_item(OP_DELETE, 32'd500, $urandom, 1'b0);
        send_item(OP_DELETE, 32'hFFFF_FFFF, $urandom, 1'b1);
        send_item(OP_SEEK, 32'hFFFF_FFFF, $urandom, 1'b0);
    endtask

    initial
    begin : stimulus
        logic [OP_W-1:0]   o;
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] v;
        logic              n;
        logic [DATA_W-1:0] dv;
        int                burst_left;
        int                gap;
        int                phase;
        int                bias;
        int                k;

        mirror = new();
        mirror.clear_table();
        settings_written = 0;
        rx_mode = 0;
        rx_tick = 0;
        rx_hold = 0;
        key_base = '0;
        key_window = 255;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random phases, each on its own register setting and operation mix.
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase % 4)
                0: dv = 32'h0000_0000;
                1: dv = 32'hFFFF_FFFF;
                2: dv = $urandom;
                default: dv = 32'h5A5A_A5A5;
            endcase
            write_defaults(dv, phase[0]);

            case (phase)
                0, 4:    bias = BIAS_FILL;
                2, 6:    bias = BIAS_DRAIN;
                1, 7:    bias = BIAS_SEEK;
                default: bias = BIAS_MIX;
            endcase
            key_base = $urandom;
            if (bias == BIAS_FILL)
                key_window = 4095;
            else
            begin
                case ($urandom_range(0, 2))
                    0: key_window = 63;
                    1: key_window = 255;
                    default: key_window = 4095;
                endcase
            end

            // Bursts of back-to-back beats separated by random gaps.
            burst_left = 0;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 60);
                    idle_cycles(gap);
                    burst_left = $urandom_range(1, 16);
                end
                pick_item(bias, o, t, v, n);
                send_item(o, t, v, n);
                burst_left--;
            end
        end

        wait_drained();
        repeat (DEPTH_DEFAULT + 10) @(posedge clk);

        $display("Ran %0d inserts, %0d deletes, %0d seeks, %0d unused codes over %0d settings.",
                 mirror.op_seen[OP_INSERT], mirror.op_seen[OP_DELETE],
                 mirror.op_seen[OP_SEEK], mirror.op_seen[OP_UNUSED], settings_written);
        $display("Peak %0d entries; %0d duplicates, %0d full drops, %0d missing, %0d defaults.",
                 mirror.peak_count, mirror.status_seen[STAT_DUP],
                 mirror.status_seen[STAT_FULL], mirror.status_seen[STAT_MISSING],
                 mirror.default_reports);
        if (mirror.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
